>>> rtl/core/msme_pkg.sv
`default_nettype none

package msme_pkg;

  // Command codes of an input transaction. Code three is served as a read.
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef logic [1:0] status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    h_rd;
    logic    h_rd_tgt;
    logic    cap_hs;
    logic    cap_hd;
    logic    m_rd;
    logic    m_rd_top;
    logic    m_wr_move;
    logic    m_wr_push;
    logic    h_wr_src;
    logic    h_wr_tgt;
    logic    status_en;
    status_t status_val;
    logic    out_load;
  } msme_dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_move;
    logic is_push;
    logic bad_idx;
    logic hs_zero;
    logic hd_zero;
    logic hd_full;
    logic cnt_zero;
    logic same;
    logic out_busy;
  } msme_dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/msme_in_if.sv
`default_nettype none

interface msme_in_if ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] stack_sel;
  logic [7:0] item;
  logic [7:0] move_count;
  logic [3:0] source_stack;
  logic [3:0] target_stack;

  modport source (
    output valid, cmd, stack_sel, item, move_count, source_stack, target_stack,
    input  ready
  );

  modport sink (
    input  valid, cmd, stack_sel, item, move_count, source_stack, target_stack,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/msme_out_if.sv
`default_nettype none

interface msme_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] top_item;
  logic [7:0] stack_height;
  logic [1:0] status;

  modport source (
    output valid, top_item, stack_height, status,
    input  ready
  );

  modport sink (
    input  valid, top_item, stack_height, status,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/msme_ram.sv
`default_nettype none

module msme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/msme_ctrl.sv
`default_nettype none

module msme_ctrl import msme_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire msme_dp_stat_t stat,
  output msme_dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_HRS, S_HRT, S_HCAP, S_MCHK, S_MWR,
    S_WB, S_WB2, S_PUSH, S_PHW, S_TOP, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.bad_idx) begin
          state_nxt = S_OUT;
        end else if (stat.is_move) begin
          state_nxt = S_HRS;
        end else begin
          state_nxt = S_HRT;
        end
      end
      S_HRS: begin
        cmd.h_rd  = 1'b1;
        state_nxt = S_HRT;
      end
      S_HRT: begin
        // The source height read last cycle is captured here.
        cmd.cap_hs   = 1'b1;
        cmd.h_rd     = 1'b1;
        cmd.h_rd_tgt = 1'b1;
        state_nxt    = S_HCAP;
      end
      S_HCAP: begin
        cmd.cap_hd = 1'b1;
        if (stat.is_move) begin
          state_nxt = S_MCHK;
        end else if (stat.is_push) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_MCHK: begin
        if (stat.cnt_zero) begin
          state_nxt = S_WB;
        end else if (stat.hs_zero) begin
          cmd.status_en  = 1'b1;
          cmd.status_val = ST_UNDER;
          state_nxt      = S_WB;
        end else if (stat.same) begin
          // Popping and pushing the same stack leaves it as it is.
          state_nxt = S_WB;
        end else if (stat.hd_full) begin
          cmd.status_en  = 1'b1;
          cmd.status_val = ST_OVER;
          state_nxt      = S_WB;
        end else begin
          cmd.m_rd  = 1'b1;
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        cmd.m_wr_move = 1'b1;
        state_nxt     = S_MCHK;
      end
      S_WB: begin
        if (stat.same) begin
          state_nxt = S_TOP;
        end else begin
          cmd.h_wr_src = 1'b1;
          state_nxt    = S_WB2;
        end
      end
      S_WB2: begin
        cmd.h_wr_tgt = 1'b1;
        state_nxt    = S_TOP;
      end
      S_PUSH: begin
        if (stat.hd_full) begin
          cmd.status_en  = 1'b1;
          cmd.status_val = ST_OVER;
          state_nxt      = S_TOP;
        end else begin
          cmd.m_wr_push = 1'b1;
          state_nxt     = S_PHW;
        end
      end
      S_PHW: begin
        cmd.h_wr_tgt = 1'b1;
        state_nxt    = S_TOP;
      end
      S_TOP: begin
        cmd.m_rd_top = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // No transaction is taken while reset is held.
  assign in_ready = rst_n && (state_r == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/msme_dp.sv
`default_nettype none

module msme_dp import msme_pkg::*; #(
  parameter int NUM_STACKS  = 16,
  parameter int STACK_DEPTH = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [1:0]   in_cmd,
  input  wire logic [3:0]   in_stack_sel,
  input  wire logic [7:0]   in_item,
  input  wire logic [7:0]   in_move_count,
  input  wire logic [3:0]   in_source_stack,
  input  wire logic [3:0]   in_target_stack,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_top_item,
  output logic [7:0]        out_stack_height,
  output logic [1:0]        out_status,
  input  wire msme_dp_cmd_t cmd,
  output msme_dp_stat_t     stat
);

  localparam int SW        = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DW        = $clog2(STACK_DEPTH);
  localparam int HW        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_STACKS * (2 ** DW);

  logic [1:0]    cmd_r;
  logic [SW-1:0] src_r, tgt_r;
  logic [7:0]    item_r, cnt_r;
  logic [HW-1:0] hs_r, hd_r;
  status_t       status_r;
  logic          bad_r, same_r;

  logic [NUM_STACKS-1:0] hvalid_r;
  logic                  hv_rd_r;
  logic [SW-1:0]         h_rd_addr, h_wr_addr;
  logic [HW-1:0]         h_wr_data, h_rdata, h_val;
  logic                  h_wr_en;

  logic [SW+DW-1:0] m_rd_addr, m_wr_addr;
  logic [7:0]       m_rdata, m_wr_data;
  logic             m_rd_en, m_wr_en;
  logic [HW-1:0]    hs_m1, hd_m1;
  logic             bad_nxt;

  logic       out_valid_r;
  logic [7:0] top_r, height_r;
  status_t    ostat_r;

  always_comb begin
    if (in_cmd == CMD_MOVE) begin
      bad_nxt = (32'(in_source_stack) >= NUM_STACKS) || (32'(in_target_stack) >= NUM_STACKS);
    end else begin
      bad_nxt = (32'(in_stack_sel) >= NUM_STACKS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      src_r    <= SW'(in_source_stack);
      tgt_r    <= (in_cmd == CMD_MOVE) ? SW'(in_target_stack) : SW'(in_stack_sel);
      item_r   <= in_item;
      cnt_r    <= in_move_count;
      same_r   <= (in_source_stack == in_target_stack);
      bad_r    <= bad_nxt;
      status_r <= ST_OK;
    end else begin
      if (cmd.status_en) begin
        status_r <= cmd.status_val;
      end
      if (cmd.cap_hs) begin
        hs_r <= h_val;
      end
      if (cmd.cap_hd) begin
        hd_r <= h_val;
      end
      if (cmd.m_wr_move) begin
        hs_r  <= hs_m1;
        hd_r  <= hd_r + HW'(1);
        cnt_r <= cnt_r - 8'd1;
      end
      if (cmd.m_wr_push) begin
        hd_r <= hd_r + HW'(1);
      end
    end
  end

  // Height counters: a RAM plus one valid bit per stack, so that a stack
  // never written reads as empty right after reset.
  assign h_rd_addr = cmd.h_rd_tgt ? tgt_r : src_r;
  assign h_wr_en   = cmd.h_wr_src | cmd.h_wr_tgt;
  assign h_wr_addr = cmd.h_wr_tgt ? tgt_r : src_r;
  assign h_wr_data = cmd.h_wr_tgt ? hd_r : hs_r;
  assign h_val     = hv_rd_r ? h_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
    end else if (h_wr_en) begin
      hvalid_r[h_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.h_rd) begin
      hv_rd_r <= hvalid_r[h_rd_addr];
    end
  end

  msme_ram #(
    .WIDTH (HW),
    .DEPTH (NUM_STACKS)
  ) u_heights (
    .clk     (clk),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data),
    .rd_en   (cmd.h_rd),
    .rd_addr (h_rd_addr),
    .rd_data (h_rdata)
  );

  // Item store, addressed as stack index above slot index.
  assign hs_m1     = hs_r - HW'(1);
  assign hd_m1     = hd_r - HW'(1);
  assign m_rd_en   = cmd.m_rd | cmd.m_rd_top;
  assign m_rd_addr = cmd.m_rd_top ? {tgt_r, hd_m1[DW-1:0]} : {src_r, hs_m1[DW-1:0]};
  assign m_wr_en   = cmd.m_wr_move | cmd.m_wr_push;
  assign m_wr_addr = {tgt_r, hd_r[DW-1:0]};
  assign m_wr_data = cmd.m_wr_push ? item_r : m_rdata;

  msme_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_items (
    .clk     (clk),
    .wr_en   (m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (m_wr_data),
    .rd_en   (m_rd_en),
    .rd_addr (m_rd_addr),
    .rd_data (m_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      top_r    <= (bad_r || hd_r == '0) ? 8'd0 : m_rdata;
      height_r <= bad_r ? 8'd0 : 8'(hd_r);
      ostat_r  <= bad_r ? ST_OK : status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_item     = top_r;
  assign out_stack_height = height_r;
  assign out_status       = ostat_r;

  assign stat.is_move  = (cmd_r == CMD_MOVE);
  assign stat.is_push  = (cmd_r == CMD_PUSH);
  assign stat.bad_idx  = bad_r;
  assign stat.hs_zero  = (hs_r == '0);
  assign stat.hd_zero  = (hd_r == '0);
  assign stat.hd_full  = (hd_r == HW'(STACK_DEPTH));
  assign stat.cnt_zero = (cnt_r == 8'd0);
  assign stat.same     = same_r;
  assign stat.out_busy = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

>>> rtl/core/multi_stack_move_engine.sv
`default_nettype none

// Bank of NUM_STACKS byte-wide LIFO stacks, each STACK_DEPTH entries deep.
// Input transactions on in_chan carry a command: push an item onto
// stack_sel, move move_count items one at a time from source_stack onto
// target_stack (their order reverses), or read stack_sel. Command code
// three is served as a read. Each input transaction yields exactly one
// result transaction on out_chan with the top item and height of the
// addressed stack (the target stack for a move) and a status.
// A stack index at or above NUM_STACKS gives an all-zero result.
// One transaction is worked on at a time, sequenced by a controller over a
// height RAM and an item RAM that each have one read and one write port.
// Every moved item costs one item RAM read and one write, and the two
// height write-backs of a move share one port.
// The result sits in an output register, so the next transaction is taken
// while it waits; when the receiver stalls, a finished result holds the
// block until the register frees up.
// Reset clears all heights at once through per-stack valid bits, so no
// clearing pass is needed and the block is ready as soon as reset ends.

module multi_stack_move_engine import msme_pkg::*; #(
  parameter int NUM_STACKS  = 16,
  parameter int STACK_DEPTH = 128
) (
  input wire logic   clk,
  input wire logic   rst_n,
  msme_in_if.sink    in_chan,
  msme_out_if.source out_chan
);

  msme_dp_cmd_t  dp_cmd;
  msme_dp_stat_t dp_stat;

  // The controller sequences each transaction; it is ready only when idle.
  msme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // The datapath holds the transaction fields, both RAMs and the result.
  msme_dp #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_chan.cmd),
    .in_stack_sel     (in_chan.stack_sel),
    .in_item          (in_chan.item),
    .in_move_count    (in_chan.move_count),
    .in_source_stack  (in_chan.source_stack),
    .in_target_stack  (in_chan.target_stack),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_top_item     (out_chan.top_item),
    .out_stack_height (out_chan.stack_height),
    .out_status       (out_chan.status),
    .cmd              (dp_cmd),
    .stat             (dp_stat)
  );

  // An item is never written onto a full stack.
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.m_wr_move || dp_cmd.m_wr_push) |-> !dp_stat.hd_full)
    else $error("item written onto a full stack");

  // A moved item always comes from a non-empty source.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.m_wr_move |-> !dp_stat.hs_zero)
    else $error("item moved from an empty stack");

  // A result is never loaded over one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> !dp_stat.out_busy)
    else $error("pending result overwritten");

  // An accepted transaction takes the block out of the ready state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("ready stayed high after an accepted transaction");

endmodule

`default_nettype wire

>>> dv/tb_multi_stack_move_engine.sv
`default_nettype none

// Testbench for the multi-stack move engine.
//
// A queue of pending stack commands is filled at time zero: a short directed
// list first, then random episodes (stack fills, gathering moves, focused
// mixes and pure noise). A clocked driver feeds that queue into the input
// channel at the falling edge, and a clocked monitor samples both channels at
// the rising edge. Every accepted input transaction is run through a local
// model of the stack bank, and the result it predicts is queued. Every
// accepted output transaction is checked against the oldest prediction.
module tb_multi_stack_move_engine;
  import msme_pkg::*;

  localparam int NUM_STACKS   = 16;
  localparam int STACK_DEPTH  = 128;
  localparam int RANDOM_OPS   = 800;
  // This limit leaves a wide margin over both the time that a move of a full
  // stack takes and the longest gap on either side.
  localparam int IDLE_LIMIT   = 5000;
  // Extra cycles after the last result, so that a stray late result shows up.
  localparam int DRAIN_CYCLES = 40;

  // One input transaction. The hold flag makes the driver wait until every
  // outstanding result has come back before it offers this command.
  typedef struct {
    logic [1:0] cmd;
    logic [3:0] stack_sel;
    logic [7:0] item;
    logic [7:0] move_count;
    logic [3:0] source_stack;
    logic [3:0] target_stack;
    bit         hold;
  } stack_op_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] top_item;
    logic [7:0] stack_height;
    logic [1:0] status;
  } stack_view_t;

  logic clk;
  logic rst_n;

  msme_in_if  in_chan ();
  msme_out_if out_chan ();

  multi_stack_move_engine #(
    .NUM_STACKS (NUM_STACKS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Local copy of the stack bank. Heights start at zero; the item array is
  // only ever read below a stack's height, so its contents before a write
  // never matter.
  logic [7:0]  item_mem  [NUM_STACKS][STACK_DEPTH];
  int unsigned stack_lvl [NUM_STACKS];

  stack_op_t   op_backlog[$];
  stack_view_t view_expected[$];

  int unsigned ops_queued;
  int unsigned ops_taken;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Handshake flag from the monitor, read by the driver at the falling edge.
  bit          in_taken;

  // Idle shaping: calm stretches have no gaps at all on either side.
  bit          calm;
  int unsigned calm_left;
  int unsigned send_gap;
  int unsigned recv_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Move counts: mostly small, so moves stay quick, with the full byte
  // range reached now and then.
  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 6));
    if (r < 90) return 8'($urandom_range(7, 40));
    if (r < 97) return 8'($urandom_range(41, 130));
    return 8'($urandom_range(131, 255));
  endfunction

  // A command with every field random; callers overwrite what matters.
  function automatic stack_op_t rand_op();
    stack_op_t op;
    op.cmd          = 2'($urandom_range(0, 3));
    op.stack_sel    = 4'($urandom_range(0, 15));
    op.item         = 8'($urandom_range(0, 255));
    op.move_count   = 8'($urandom_range(0, 255));
    op.source_stack = 4'($urandom_range(0, 15));
    op.target_stack = 4'($urandom_range(0, 15));
    op.hold         = 1'b0;
    return op;
  endfunction

  // Top item and height of one stack together with a status.
  function automatic stack_view_t view_of(int unsigned idx, logic [1:0] st);
    stack_view_t v;
    v.status       = st;
    v.stack_height = 8'(stack_lvl[idx]);
    v.top_item     = (stack_lvl[idx] == 0) ? 8'h00 : item_mem[idx][stack_lvl[idx] - 1];
    return v;
  endfunction

  // Applies one command to the local stack bank and returns its result.
  function automatic stack_view_t apply_stack_op(stack_op_t op);
    stack_view_t v;
    int unsigned sel;
    int unsigned src;
    int unsigned dst;
    int unsigned hs;
    int unsigned hd;
    logic [1:0]  st;
    v   = '0;
    st  = ST_OK;
    sel = op.stack_sel;
    src = op.source_stack;
    dst = op.target_stack;
    if (op.cmd == CMD_PUSH) begin
      if (sel >= NUM_STACKS) return v;
      // A push onto a full stack drops the item and flags overflow.
      if (stack_lvl[sel] >= STACK_DEPTH) begin
        st = ST_OVER;
      end else begin
        item_mem[sel][stack_lvl[sel]] = op.item;
        stack_lvl[sel]++;
      end
      return view_of(sel, st);
    end
    if (op.cmd == CMD_MOVE) begin
      if (src >= NUM_STACKS || dst >= NUM_STACKS) return v;
      // Items go over one at a time. An empty source stops the move with
      // underflow, a full target stops it with overflow, and items already
      // moved stay where they went. Moving a stack onto itself leaves it
      // unchanged but still underflows when it is empty.
      for (int unsigned k = 0; k < op.move_count; k++) begin
        hs = stack_lvl[src];
        if (hs == 0) begin
          st = ST_UNDER;
          break;
        end
        if (src == dst) continue;
        hd = stack_lvl[dst];
        if (hd >= STACK_DEPTH) begin
          st = ST_OVER;
          break;
        end
        item_mem[dst][hd] = item_mem[src][hs - 1];
        stack_lvl[dst]    = hd + 1;
        stack_lvl[src]    = hs - 1;
      end
      return view_of(dst, st);
    end
    // Read, and the unused fourth code which behaves as a read.
    if (sel >= NUM_STACKS) return v;
    return view_of(sel, ST_OK);
  endfunction

  function automatic void queue_op(stack_op_t op);
    op_backlog.push_back(op);
    ops_queued++;
  endfunction

  task automatic note_mismatch(string what, stack_view_t exp_v, stack_view_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected top=%0d height=%0d status=%0d, got top=%0d height=%0d status=%0d",
               what, exp_v.top_item, exp_v.stack_height, exp_v.status,
               got.top_item, got.stack_height, got.status);
    end
  endtask

  // Directed commands: empty reads, the fourth code, byte extremes, zero
  // counts, moves from an empty stack, a stack moved onto itself both empty
  // and filled, and moves with the largest counts.
  task automatic build_directed();
    stack_op_t op;
    op = rand_op(); op.cmd = CMD_READ; op.stack_sel = 4'd0;  queue_op(op);
    op = rand_op(); op.cmd = 2'd3;     op.stack_sel = 4'd15; queue_op(op);
    op = rand_op(); op.cmd = CMD_PUSH; op.stack_sel = 4'd0;  op.item = 8'h00; queue_op(op);
    op = rand_op(); op.cmd = CMD_PUSH; op.stack_sel = 4'd0;  op.item = 8'hFF; queue_op(op);
    op = rand_op(); op.cmd = CMD_PUSH; op.stack_sel = 4'd15; op.item = 8'hA5; queue_op(op);
    op = rand_op(); op.cmd = 2'd3;     op.stack_sel = 4'd0;  queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd0;
    op.source_stack = 4'd0; op.target_stack = 4'd1; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd1;
    op.source_stack = 4'd0; op.target_stack = 4'd1; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd5;
    op.source_stack = 4'd0; op.target_stack = 4'd0; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd3;
    op.source_stack = 4'd2; op.target_stack = 4'd2; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd1;
    op.source_stack = 4'd3; op.target_stack = 4'd4; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd255;
    op.source_stack = 4'd0; op.target_stack = 4'd15; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd128;
    op.source_stack = 4'd15; op.target_stack = 4'd0; queue_op(op);
    op = rand_op(); op.cmd = CMD_PUSH; op.stack_sel = 4'd7; op.item = 8'h5A; queue_op(op);
    op = rand_op(); op.cmd = CMD_READ; op.stack_sel = 4'd7; queue_op(op);
    op = rand_op(); op.cmd = CMD_MOVE; op.move_count = 8'd0;
    op.source_stack = 4'd15; op.target_stack = 4'd15; queue_op(op);
    op = rand_op(); op.cmd = CMD_READ; op.stack_sel = 4'd1; queue_op(op);
  endtask

  // Random episodes. Fills drive single stacks toward their depth and at times past it,
  // gathers pile several stacks onto one so that moves hit a full target,
  // focused mixes keep a few stacks busy, and noise uses any field value.
  task automatic build_random();
    stack_op_t   op;
    int unsigned base;
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned s;
    int unsigned hot [3];
    bit          first;
    base  = ops_queued;
    first = 1'b1;
    while (ops_queued - base < RANDOM_OPS) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) hot[i] = $urandom_range(0, 15);
      if (kind == 0) begin
        s = hot[0];
        n = $urandom_range(16, 140);
        for (int i = 0; i < n; i++) begin
          op = rand_op();
          op.stack_sel = 4'(s);
          op.cmd = ($urandom_range(0, 9) == 0) ? CMD_READ : CMD_PUSH;
          op.hold = first;
          first = 1'b0;
          queue_op(op);
        end
      end else if (kind <= 2) begin
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) begin
          op = rand_op();
          op.cmd = CMD_MOVE;
          op.target_stack = 4'(hot[0]);
          op.move_count = pick_count();
          op.hold = first;
          first = 1'b0;
          queue_op(op);
        end
        op = rand_op(); op.cmd = CMD_READ; op.stack_sel = 4'(hot[0]); queue_op(op);
      end else begin
        n = (kind == 9) ? 10 : 20;
        for (int i = 0; i < n; i++) begin
          op = rand_op();
          if (kind != 9) begin
            r = $urandom_range(0, 99);
            op.stack_sel    = 4'(hot[$urandom_range(0, 2)]);
            op.source_stack = 4'(hot[$urandom_range(0, 2)]);
            op.target_stack = 4'(hot[$urandom_range(0, 2)]);
            op.move_count   = pick_count();
            if (r < 45)      op.cmd = CMD_PUSH;
            else if (r < 75) op.cmd = CMD_MOVE;
            else if (r < 95) op.cmd = CMD_READ;
            else             op.cmd = 2'd3;
          end
          // Every so often the sender waits for the block to drain.
          op.hold = first || ($urandom_range(0, 99) == 0);
          first = 1'b0;
          queue_op(op);
        end
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.cmd           = CMD_READ;
    in_chan.stack_sel     = '0;
    in_chan.item          = '0;
    in_chan.move_count    = '0;
    in_chan.source_stack  = '0;
    in_chan.target_stack  = '0;
    out_chan.ready        = 1'b0;
    ops_queued            = 0;
    ops_taken             = 0;
    mismatches            = 0;
    idle_cycles           = 0;
    in_taken              = 1'b0;
    calm                  = 1'b0;
    calm_left             = 0;
    send_gap              = 0;
    recv_stall            = 0;
    for (int i = 0; i < NUM_STACKS; i++) stack_lvl[i] = 0;
    build_directed();
    build_random();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Wait until the whole backlog has been taken and answered.
    while (ops_taken != ops_queued) @(posedge clk);
    while (view_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Driver and receiver, both acting at the falling edge. The input valid is
  // computed once per cycle and assigned once, so a transaction that is
  // followed directly by the next one keeps valid high without a glitch.
  always @(negedge clk) begin : drive_ops
    logic      vld_nxt;
    stack_op_t op;
    if (rst_n) begin
      // Alternate between stretches with idling and calm ones without it.
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(40, 300);
      end

      vld_nxt = in_chan.valid && !in_taken;
      if (!vld_nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (op_backlog.size() != 0 &&
                     !(op_backlog[0].hold && view_expected.size() != 0)) begin
          op = op_backlog.pop_front();
          in_chan.cmd          <= op.cmd;
          in_chan.stack_sel    <= op.stack_sel;
          in_chan.item         <= op.item;
          in_chan.move_count   <= op.move_count;
          in_chan.source_stack <= op.source_stack;
          in_chan.target_stack <= op.target_stack;
          vld_nxt  = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_chan.valid <= vld_nxt;

      // The receiver stalls now and then, for the same spread of lengths.
      if (recv_stall == 0 && $urandom_range(0, 5) == 0) recv_stall = pick_gap();
      if (recv_stall > 0) begin
        out_chan.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Monitor at the rising edge: checks results, then predicts the result of
  // a newly accepted command. A result can never belong to a command taken
  // at the same edge, so checking first is safe.
  always @(posedge clk) begin : watch_ops
    stack_op_t   op;
    stack_view_t got;
    stack_view_t exp_v;
    bit          out_fire;
    in_taken = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      in_taken = in_chan.valid && in_chan.ready;
      out_fire = out_chan.valid && out_chan.ready;

      if (out_fire) begin
        got.top_item     = out_chan.top_item;
        got.stack_height = out_chan.stack_height;
        got.status       = out_chan.status;
        if (view_expected.size() == 0) begin
          note_mismatch("no result pending", '0, got);
        end else begin
          exp_v = view_expected.pop_front();
          if (got.top_item !== exp_v.top_item ||
              got.stack_height !== exp_v.stack_height ||
              got.status !== exp_v.status) begin
            note_mismatch("field", exp_v, got);
          end
        end
      end

      if (in_taken) begin
        op.cmd          = in_chan.cmd;
        op.stack_sel    = in_chan.stack_sel;
        op.item         = in_chan.item;
        op.move_count   = in_chan.move_count;
        op.source_stack = in_chan.source_stack;
        op.target_stack = in_chan.target_stack;
        op.hold         = 1'b0;
        view_expected.push_back(apply_stack_op(op));
        ops_taken++;
      end

      if (in_taken || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
  end

endmodule

`default_nettype wire
